[src/ptt_pkg.sv]
`default_nettype none
package ptt_pkg;

	localparam int RESULT_CAP  = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int FOUND_W     = $clog2(RESULT_CAP + 1);

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_WAKE = 2'd1;
	localparam logic [1:0] OP_DUE  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [2:0] KIND_ADDED    = 3'd0;
	localparam logic [2:0] KIND_FULL     = 3'd1;
	localparam logic [2:0] KIND_WAKE     = 3'd2;
	localparam logic [2:0] KIND_NOTHING  = 3'd3;
	localparam logic [2:0] KIND_DUE      = 3'd4;
	localparam logic [2:0] KIND_NONE_DUE = 3'd5;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now;
		logic [31:0] start;
		logic [31:0] period;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] number;
		logic [32:0] wake;
		logic        last;
	} res_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_EVAL,
		ST_MOVE,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

[src/ptt_fifo.sv]
`default_nettype none
module ptt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [NW-1:0]    n_q;
	logic             do_push, do_pop;

	assign full    = (n_q == NW'(DEPTH));
	assign empty   = (n_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q  <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   n_q <= n_q + 1'b1;
				2'b01:   n_q <= n_q - 1'b1;
				default: n_q <= n_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/ptt_mod.sv]
`default_nettype none
module ptt_mod
	import ptt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [31:0] a_q, b_q;
	logic [32:0] r_q;
	logic [32:0] shifted;

	assign shifted  = {r_q[31:0], a_q[31]};
	assign rsp.done = done_q;
	assign rsp.rem  = r_q[31:0];

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.dividend;
			b_q <= req.divisor;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[30:0], 1'b0};
			r_q <= (shifted >= {1'b0, b_q}) ? shifted - {1'b0, b_q} : shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

[src/ptt_back.sv]
`default_nettype none
module ptt_back
	import ptt_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_avail,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	input  wire logic res_full,
	output logic      res_push,
	output res_t      res
);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t               state_q, nxt_state, ret_q;
	cmd_t                 cmd_q;
	logic [CW-1:0]        idx_q, count_q, last_idx;
	logic [15:0]          ident_q, pend_q;
	logic                 have_q;
	logic [32:0]          best_q;
	logic [FOUND_W-1:0]   found_q;
	res_t                 res_q;

	logic [31:0] mem_start  [SLOTS];
	logic [31:0] mem_period [SLOTS];
	logic [15:0] mem_ident  [SLOTS];
	logic [31:0] rd_start_q, rd_period_q;
	logic [15:0] rd_ident_q;

	div_req_t dreq;
	div_rsp_t drsp;

	logic        is_wake, is_due, lt, eq, need_div, drop_now, scan_end, is_full;
	logic        got_t, got_due, step_done, rd_en;
	logic [32:0] t_val;
	logic [CW-1:0] rd_addr;

	ptt_mod u_mod (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign is_wake  = (cmd_q.op == OP_WAKE);
	assign is_due   = (cmd_q.op == OP_DUE);
	assign is_full  = (count_q == CW'(SLOTS));
	assign last_idx = count_q - 1'b1;
	assign lt       = cmd_q.now < rd_start_q;
	assign eq       = cmd_q.now == rd_start_q;
	assign need_div = !lt && (rd_period_q != '0) && !(is_due && eq);
	assign drop_now = (state_q == ST_EVAL) && is_wake && !lt && (rd_period_q == '0);
	assign scan_end = (idx_q >= count_q) || (found_q == FOUND_W'(RESULT_CAP));

	assign dreq.start    = (state_q == ST_EVAL) && need_div;
	assign dreq.dividend = cmd_q.now - rd_start_q;
	assign dreq.divisor  = rd_period_q;

	always_comb begin
		got_t     = 1'b0;
		got_due   = 1'b0;
		step_done = 1'b0;
		t_val     = {1'b0, rd_start_q};
		if (state_q == ST_EVAL && !need_div && !drop_now) begin
			step_done = 1'b1;
			got_t     = is_wake;
			got_due   = is_due && eq;
		end else if (state_q == ST_DIV && drop_now == 1'b0 && drsp.done) begin
			step_done = 1'b1;
			got_t     = is_wake;
			got_due   = is_due && (drsp.rem == '0);
			t_val     = {1'b0, cmd_q.now} + {1'b0, rd_period_q} - {1'b0, drsp.rem};
		end
	end

	// next state
	always_comb begin
		nxt_state = state_q;
		case (state_q)
			ST_IDLE:   if (cmd_avail) nxt_state = ST_DECODE;
			ST_DECODE: begin
				case (cmd_q.op)
					OP_ADD:          nxt_state = ST_EMIT;
					OP_WAKE, OP_DUE: nxt_state = ST_READ;
					default:         nxt_state = ST_IDLE;
				endcase
			end
			ST_READ:   nxt_state = scan_end ? ST_EMIT : ST_EVAL;
			ST_EVAL: begin
				if (drop_now) begin
					nxt_state = (idx_q == last_idx) ? ST_READ : ST_MOVE;
				end else if (need_div) begin
					nxt_state = ST_DIV;
				end else if (got_due && found_q != '0) begin
					nxt_state = ST_EMIT;
				end else begin
					nxt_state = ST_READ;
				end
			end
			ST_MOVE:   nxt_state = ST_READ;
			ST_DIV: begin
				if (drsp.done) begin
					nxt_state = (got_due && found_q != '0) ? ST_EMIT : ST_READ;
				end
			end
			ST_EMIT:   if (!res_full) nxt_state = ret_q;
			default:   nxt_state = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop  = (state_q == ST_IDLE) && cmd_avail;
		res_push = (state_q == ST_EMIT) && !res_full;
		res      = res_q;
		rd_en    = (state_q == ST_READ) || drop_now;
		rd_addr  = (state_q == ST_EVAL) ? last_idx : idx_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECODE && cmd_q.op == OP_ADD && !is_full) begin
			mem_start[count_q[AW-1:0]]  <= cmd_q.start;
			mem_period[count_q[AW-1:0]] <= cmd_q.period;
			mem_ident[count_q[AW-1:0]]  <= ident_q;
		end else if (state_q == ST_MOVE) begin
			mem_start[idx_q[AW-1:0]]  <= rd_start_q;
			mem_period[idx_q[AW-1:0]] <= rd_period_q;
			mem_ident[idx_q[AW-1:0]]  <= rd_ident_q;
		end
		if (rd_en) begin
			rd_start_q  <= mem_start[rd_addr[AW-1:0]];
			rd_period_q <= mem_period[rd_addr[AW-1:0]];
			rd_ident_q  <= mem_ident[rd_addr[AW-1:0]];
		end
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			count_q <= '0;
			ident_q <= 16'd1;
			idx_q   <= '0;
			have_q  <= 1'b0;
			best_q  <= '0;
			found_q <= '0;
			pend_q  <= '0;
			res_q   <= '0;
		end else begin
			state_q <= nxt_state;
			case (state_q)
				ST_DECODE: begin
					idx_q   <= '0;
					have_q  <= 1'b0;
					found_q <= '0;
					ret_q   <= ST_IDLE;
					if (cmd_q.op == OP_ADD) begin
						if (is_full) begin
							res_q <= '{kind: KIND_FULL, number: '0, wake: '0, last: 1'b1};
						end else begin
							res_q   <= '{kind: KIND_ADDED, number: ident_q, wake: '0, last: 1'b1};
							count_q <= count_q + 1'b1;
							ident_q <= (ident_q == 16'hFFFF) ? 16'd1 : ident_q + 1'b1;
						end
					end
				end
				ST_READ: begin
					if (scan_end) begin
						ret_q <= ST_IDLE;
						if (is_wake) begin
							res_q <= have_q
								? '{kind: KIND_WAKE, number: '0, wake: best_q, last: 1'b1}
								: '{kind: KIND_NOTHING, number: '0, wake: '0, last: 1'b1};
						end else begin
							res_q <= (found_q == '0)
								? '{kind: KIND_NONE_DUE, number: '0, wake: '0, last: 1'b1}
								: '{kind: KIND_DUE, number: pend_q, wake: '0, last: 1'b1};
						end
					end
				end
				default: ;
			endcase
			if (drop_now) begin
				count_q <= count_q - 1'b1;
			end
			if (step_done) begin
				idx_q <= idx_q + 1'b1;
				if (got_t && (!have_q || t_val < best_q)) begin
					best_q <= t_val;
					have_q <= 1'b1;
				end
				if (got_due) begin
					if (found_q != '0) begin
						res_q <= '{kind: KIND_DUE, number: pend_q, wake: '0, last: 1'b0};
						ret_q <= ST_READ;
					end
					pend_q  <= rd_ident_q;
					found_q <= found_q + 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS)) else $error("entry count beyond table size");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result transfer into full queue");
	a_div_return: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |=> state_q == ST_DIV) else $error("modulo started outside wait");
	a_ident_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ident_q != '0) else $error("identifier counter hit zero");
`endif

endmodule
`default_nettype wire

[src/periodic_task_timer_table_core.sv]
// channel  | handshake       | fields
// input    | push / full     | operation, current_time, start_time, repeat_period
// result   | pop / empty     | kind, task_number, wake_time, last
//
// a query reads and evaluates each entry in turn, running the shared bit-serial
// modulo unit for an entry at or past its start with a nonzero period, except a due
// query at the exact start time; one query walks up to TASK_SLOTS entries
// reset clears entry count and both queues and sets the identifier to 1; no table sweep
// the front queue takes items while the back walks; the back stalls on a full result queue
`default_nettype none
module periodic_task_timer_table_core
	import ptt_pkg::*;
#(
	parameter int TASK_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] current_time,
	input  wire logic [31:0] start_time,
	input  wire logic [31:0] repeat_period,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       kind,
	output logic [15:0]      task_number,
	output logic [32:0]      wake_time,
	output logic             last
);
	cmd_t in_cmd, q_cmd;
	res_t b_res, q_res;
	logic in_push, q_empty, b_pop, r_full, b_push;

	assign in_cmd  = '{op: operation, now: current_time, start: start_time,
		period: repeat_period};
	// unused operation transfers but is not queued
	assign in_push = push && (operation != OP_NONE);

	ptt_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
		.clk(clk), .arst_n(arst_n),
		.push(in_push), .wdata(in_cmd), .full(full),
		.pop(b_pop), .rdata(q_cmd), .empty(q_empty)
	);

	ptt_back #(.SLOTS(TASK_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_avail(!q_empty), .cmd(q_cmd), .cmd_pop(b_pop),
		.res_full(r_full), .res_push(b_push), .res(b_res)
	);

	ptt_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n),
		.push(b_push), .wdata(b_res), .full(r_full),
		.pop(pop), .rdata(q_res), .empty(empty)
	);

	assign kind        = q_res.kind;
	assign task_number = q_res.number;
	assign wake_time   = q_res.wake;
	assign last        = q_res.last;

endmodule
`default_nettype wire

[tb/periodic_task_timer_table_core_tb.sv]
module periodic_task_timer_table_core_tb;
	import ptt_pkg::*;

	localparam int SLOTS = 16;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now;
		logic [31:0] start;
		logic [31:0] period;
	} job_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] number;
		logic [32:0] wake;
		logic        last;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [1:0] operation = OP_NONE;
	logic [31:0] current_time = 0;
	logic [31:0] start_time = 0;
	logic [31:0] repeat_period = 0;
	logic empty;
	logic pop = 0;
	logic [2:0] kind;
	logic [15:0] task_number;
	logic [32:0] wake_time;
	logic last;

	periodic_task_timer_table_core #(.TASK_SLOTS(SLOTS)) uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.operation(operation), .current_time(current_time),
		.start_time(start_time), .repeat_period(repeat_period),
		.empty(empty), .pop(pop), .kind(kind), .task_number(task_number),
		.wake_time(wake_time), .last(last)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	job_t pending_jobs[$];
	answer_t expected_answers[$];
	logic [31:0] tbl_start[SLOTS];
	logic [31:0] tbl_period[SLOTS];
	logic [15:0] tbl_ident[SLOTS];
	int tbl_count = 0;
	logic [15:0] next_ident = 1;
	int errors = 0;
	int jobs_sent = 0;
	int answers_seen = 0;
	int due_answers = 0;
	int full_answers = 0;
	int send_idle = 0;
	int take_idle = 0;
	int hold_cycles = 0;
	bit calm = 0;
	bit stim_done = 0;
	int quiet = 0;

	task automatic report(input string what, input logic [32:0] got, input logic [32:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic push_answer(input logic [2:0] k, input logic [15:0] n,
			input logic [32:0] w, input logic l);
		answer_t a;
		a.kind = k;
		a.number = n;
		a.wake = w;
		a.last = l;
		expected_answers.push_back(a);
	endtask

	task automatic schedule_step(input job_t j);
		int i;
		int n;
		bit have;
		logic [32:0] best;
		logic [32:0] t;
		bit due;
		case (j.op)
			OP_ADD: begin
				if (tbl_count >= SLOTS) begin
					push_answer(KIND_FULL, 0, 0, 1);
				end else begin
					tbl_start[tbl_count] = j.start;
					tbl_period[tbl_count] = j.period;
					tbl_ident[tbl_count] = next_ident;
					tbl_count++;
					push_answer(KIND_ADDED, next_ident, 0, 1);
					next_ident = (next_ident == 16'hffff) ? 16'd1 : next_ident + 16'd1;
				end
			end
			OP_WAKE: begin
				have = 0;
				best = 0;
				i = 0;
				while (i < tbl_count) begin
					if (j.now < tbl_start[i]) begin
						t = {1'b0, tbl_start[i]};
					end else if (tbl_period[i] == 0) begin
						tbl_count--;
						tbl_start[i] = tbl_start[tbl_count];
						tbl_period[i] = tbl_period[tbl_count];
						tbl_ident[i] = tbl_ident[tbl_count];
						continue;
					end else begin
						t = {1'b0, j.now} + {1'b0, tbl_period[i]}
							- {1'b0, (j.now - tbl_start[i]) % tbl_period[i]};
					end
					if (!have || t < best) begin
						best = t;
						have = 1;
					end
					i++;
				end
				if (have) push_answer(KIND_WAKE, 0, best, 1);
				else push_answer(KIND_NOTHING, 0, 0, 1);
			end
			OP_DUE: begin
				n = 0;
				for (i = 0; i < tbl_count && n < RESULT_CAP; i++) begin
					due = (j.now == tbl_start[i]) || (j.now > tbl_start[i]
						&& tbl_period[i] != 0
						&& ((j.now - tbl_start[i]) % tbl_period[i]) == 0);
					if (due) begin
						push_answer(KIND_DUE, tbl_ident[i], 0, 0);
						n++;
					end
				end
				if (n == 0) push_answer(KIND_NONE_DUE, 0, 0, 1);
				else expected_answers[expected_answers.size() - 1].last = 1;
			end
			default: begin
			end
		endcase
	endtask

	function automatic job_t make_job(input logic [1:0] op, input logic [31:0] now,
			input logic [31:0] st, input logic [31:0] per);
		job_t j;
		j.op = op;
		j.now = now;
		j.start = st;
		j.period = per;
		return j;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return $urandom_range(0, 40);
			3: return 32'hffffffff - $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				schedule_step(make_job(operation, current_time, start_time, repeat_period));
				jobs_sent++;
			end
			if (!(push && full)) begin
				if (send_idle > 0) begin
					send_idle <= send_idle - 1;
					push <= 0;
				end else if (pending_jobs.size() > 0 && (calm || $urandom_range(0, 9) != 0)) begin
					push <= 1;
					operation <= pending_jobs[0].op;
					current_time <= pending_jobs[0].now;
					start_time <= pending_jobs[0].start;
					repeat_period <= pending_jobs[0].period;
					void'(pending_jobs.pop_front());
				end else begin
					push <= 0;
					if (!calm && pending_jobs.size() > 0) send_idle <= $urandom_range(1, 9);
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				answers_seen++;
				if (kind == KIND_DUE) due_answers++;
				if (kind == KIND_FULL) full_answers++;
				if (expected_answers.size() == 0) begin
					$display("unexpected transfer at %0t: kind %0d", $realtime, kind);
					errors++;
				end else begin
					want = expected_answers.pop_front();
					if (kind !== want.kind) report("kind", kind, want.kind);
					if (task_number !== want.number) report("task_number", task_number, want.number);
					if (wake_time !== want.wake) report("wake_time", wake_time, want.wake);
					if (last !== want.last) report("last", last, want.last);
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				pop <= 0;
			end else if (take_idle > 0) begin
				take_idle <= take_idle - 1;
				pop <= 0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				take_idle <= $urandom_range(1, 9);
				pop <= 0;
			end else begin
				pop <= 1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || hold_cycles > 0) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic add_burst(input int cnt, input logic [31:0] base);
		int k;
		for (k = 0; k < cnt; k++)
			pending_jobs.push_back(make_job(OP_ADD, rand_word(),
				base + $urandom_range(0, 20), $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7)));
	endtask

	initial begin
		int k;
		int r;
		logic [31:0] base;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// directed
		pending_jobs.push_back(make_job(OP_WAKE, 0, 0, 0));
		pending_jobs.push_back(make_job(OP_DUE, 0, 0, 0));
		pending_jobs.push_back(make_job(OP_ADD, 0, 32'hffffffff, 32'hffffffff));
		pending_jobs.push_back(make_job(OP_ADD, 32'hffffffff, 5, 0));
		pending_jobs.push_back(make_job(OP_ADD, 0, 0, 1));
		pending_jobs.push_back(make_job(OP_ADD, 0, 10, 0));
		pending_jobs.push_back(make_job(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff));
		pending_jobs.push_back(make_job(OP_DUE, 5, 0, 0));
		pending_jobs.push_back(make_job(OP_DUE, 10, 0, 0));
		pending_jobs.push_back(make_job(OP_WAKE, 32'hfffffffe, 0, 0));
		pending_jobs.push_back(make_job(OP_DUE, 32'hffffffff, 0, 0));
		pending_jobs.push_back(make_job(OP_WAKE, 32'hffffffff, 0, 0));
		for (k = 0; k < 14; k++) pending_jobs.push_back(make_job(OP_ADD, 0, 100, 0));
		pending_jobs.push_back(make_job(OP_ADD, 0, 1, 1));
		pending_jobs.push_back(make_job(OP_DUE, 100, 0, 0));
		pending_jobs.push_back(make_job(OP_WAKE, 200, 0, 0));
		// long receiver hold while the sender keeps offering
		wait (pending_jobs.size() < 6);
		@(posedge clk);
		hold_cycles <= 400;
		// random scenarios around a shared time base
		while (jobs_sent + pending_jobs.size() < 430) begin
			base = rand_word();
			add_burst($urandom_range(1, 18), base);
			for (k = 0; k < 8; k++) begin
				r = $urandom_range(0, 9);
				if (r < 4) pending_jobs.push_back(make_job(OP_DUE,
					base + $urandom_range(0, 30), rand_word(), rand_word()));
				else if (r < 7) pending_jobs.push_back(make_job(OP_WAKE,
					base + $urandom_range(0, 30), rand_word(), rand_word()));
				else if (r < 9) pending_jobs.push_back(make_job(OP_ADD,
					rand_word(), rand_word(), rand_word()));
				else pending_jobs.push_back(make_job(OP_NONE,
					rand_word(), rand_word(), rand_word()));
			end
			pending_jobs.push_back(make_job(OP_WAKE, 32'hffffffff, 0, 0));
			while (pending_jobs.size() > 40) @(posedge clk);
		end
		wait (pending_jobs.size() == 0);
		calm = 1;
		for (k = 0; k < 30; k++)
			pending_jobs.push_back(make_job($urandom_range(0, 2), rand_word(),
				rand_word(), rand_word()));
		wait (pending_jobs.size() == 0 && !push);
		wait (expected_answers.size() == 0);
		repeat (1000) @(posedge clk);
		$display("%0d commands and %0d results checked, including %0d due tasks and %0d full-table",
			jobs_sent, answers_seen, due_answers, full_answers);
		$display("adds, wake and due queries, spent one-shot removal and a long result stall");
		if (errors == 0 && expected_answers.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
src/ptt_pkg.sv
src/ptt_fifo.sv
src/ptt_mod.sv
src/ptt_back.sv
src/periodic_task_timer_table_core.sv
tb/periodic_task_timer_table_core_tb.sv
